/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define IRT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, idle during reset
`define IRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/irt_pkg.sv */
// ----------------------------------------------------------------------------
// irt_pkg
// Types and constants of the interval reservation table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irt_pkg;

  localparam int IN_BITS  = 32;
  localparam int REQ_BITS = 32;

  // result status codes
  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_OVERLAP  = 2'd1,
    ST_FULL     = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/irt_if.sv */
// ----------------------------------------------------------------------------
// irt_if
// Valid/ready channels for requests and results of the reservation table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface irt_in_if;
  logic                          valid;
  logic                          ready;
  logic [irt_pkg::IN_BITS-1:0]   range_start;
  logic [irt_pkg::IN_BITS-1:0]   range_end;

  modport source (output valid, output range_start, output range_end, input ready);
  modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

interface irt_out_if;
  logic                          valid;
  logic                          ready;
  irt_pkg::status_t              status;
  logic [irt_pkg::REQ_BITS-1:0]  request_number;

  modport source (output valid, output status, output request_number, input ready);
  modport sink   (input valid, input status, input request_number, output ready);
endinterface

`default_nettype wire

/* hw/rtl/irt_ram.sv */
// ----------------------------------------------------------------------------
// irt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/interval_reservation_table.sv */
// ----------------------------------------------------------------------------
// interval_reservation_table
// Stores closed time ranges and admits a new one only if it clashes with none.
// ----------------------------------------------------------------------------
// Each request [range_start, range_end] gets one result: its running number
// and a status (accepted, overlap, table full, start after end). Ranges that
// touch at an endpoint clash; stored ranges are never released. Stored ranges
// sit in one RAM, and a single compare unit checks them one entry per cycle
// through the RAM's registered read port; a request with start after end,
// one against a full table and one against an empty table skips the scan
// and goes straight to the result. The result waits in an output register,
// so the next request may be taken while it is still pending; a request
// only finishes once that register is free, so a stalled result side holds
// off the input. Time values are taken modulo 2^TIME_BITS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module interval_reservation_table #(
  parameter int TABLE_CAPACITY = 64,
  parameter int TIME_BITS      = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  irt_in_if.sink     in_ch,
  irt_out_if.source  out_ch
);

  localparam int AW = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
  localparam int CW = $clog2(TABLE_CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(TABLE_CAPACITY);

  irt_pkg::state_t  state_r, state_nxt;

  logic [TIME_BITS-1:0]          lo_r, hi_r;
  logic [TIME_BITS-1:0]          lo_in, hi_in;
  logic [irt_pkg::REQ_BITS-1:0]  req_cnt_r, req_cnt_nxt;
  irt_pkg::status_t              status_r;
  logic                          hit_r;
  logic [CW-1:0]                 rd_idx_r;
  logic                          data_v_r;
  logic [CW-1:0]                 count_r;
  logic                          out_valid_r;
  irt_pkg::status_t              out_status_r;
  logic [irt_pkg::REQ_BITS-1:0]  out_req_r;

  logic                          in_xfer;
  logic                          issue;
  logic                          scan_done;
  logic                          load_out;
  logic                          store;
  logic                          match;
  logic [2*TIME_BITS-1:0]        rd_data;
  logic [TIME_BITS-1:0]          e_start, e_end;

  // input fields reduced to the time width
  assign lo_in = TIME_BITS'(in_ch.range_start);
  assign hi_in = TIME_BITS'(in_ch.range_end);

  // running number skips zero on wrap
  always_comb begin
    req_cnt_nxt = req_cnt_r + irt_pkg::REQ_BITS'(1);
    if (req_cnt_nxt == '0) begin
      req_cnt_nxt = irt_pkg::REQ_BITS'(1);
    end
  end

  // shared compare unit on the entry just read
  assign e_start = rd_data[TIME_BITS-1:0];
  assign e_end   = rd_data[2*TIME_BITS-1:TIME_BITS];
  assign match   = (lo_r <= e_end) && (e_start <= hi_r);

  // range table storage, start in the low half
  irt_ram #(
    .WIDTH (2 * TIME_BITS),
    .DEPTH (TABLE_CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (store),
    .waddr (count_r[AW-1:0]),
    .wdata ({hi_r, lo_r}),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  // sequencer: next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_xfer   = 1'b0;
    issue     = 1'b0;
    scan_done = 1'b0;
    load_out  = 1'b0;
    store     = 1'b0;
    case (state_r)
      irt_pkg::S_IDLE: begin
        in_xfer = in_ch.valid;
        if (in_ch.valid) begin
          if ((lo_in > hi_in) || (count_r >= CAP_C) || (count_r == '0)) begin
            state_nxt = irt_pkg::S_FINISH;
          end else begin
            state_nxt = irt_pkg::S_SCAN;
          end
        end
      end
      irt_pkg::S_SCAN: begin
        issue     = (rd_idx_r < count_r);
        scan_done = !issue && !data_v_r;
        if (scan_done) begin
          state_nxt = irt_pkg::S_FINISH;
        end
      end
      irt_pkg::S_FINISH: begin
        load_out = !out_valid_r || out_ch.ready;
        store    = load_out && (status_r == irt_pkg::ST_ACCEPTED);
        if (load_out) begin
          state_nxt = irt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = irt_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= irt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      req_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      data_v_r    <= 1'b0;
    end else begin
      if (in_xfer) begin
        req_cnt_r <= req_cnt_nxt;
      end
      if (store) begin
        count_r <= count_r + CW'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      data_v_r <= issue;
    end
  end

  // request and scan datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lo_r     <= lo_in;
      hi_r     <= hi_in;
      hit_r    <= 1'b0;
      rd_idx_r <= '0;
      if (lo_in > hi_in) begin
        status_r <= irt_pkg::ST_INVALID;
      end else if (count_r >= CAP_C) begin
        status_r <= irt_pkg::ST_FULL;
      end else begin
        status_r <= irt_pkg::ST_ACCEPTED;
      end
    end
    if (issue) begin
      rd_idx_r <= rd_idx_r + CW'(1);
    end
    if (data_v_r && match) begin
      hit_r <= 1'b1;
    end
    if (scan_done) begin
      status_r <= hit_r ? irt_pkg::ST_OVERLAP : irt_pkg::ST_ACCEPTED;
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_req_r    <= req_cnt_r;
    end
  end

  // channel outputs
  assign in_ch.ready           = (state_r == irt_pkg::S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.request_number = out_req_r;

  // checks
  `IRT_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_ch.valid && in_ch.ready, state_r != irt_pkg::S_IDLE)
  `IRT_ASSERT_NEXT(a_count_on_store, clk, rst_n, store, count_r == $past(count_r) + CW'(1))
  `IRT_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CAP_C)
  `IRT_ASSERT_IMPLY(a_scan_in_range, clk, rst_n, state_r == irt_pkg::S_SCAN, rd_idx_r <= count_r)

endmodule

`default_nettype wire

/* dv/irt_booking_checker.sv */
// ----------------------------------------------------------------------------
// irt_booking_checker
// Watches both channels of the reservation table. Each request transfer is
// booked into a local copy of the table to give the expected status and
// running number. Each result transfer is compared with the oldest of these.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irt_booking_checker #(
  parameter int TABLE_CAPACITY = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [irt_pkg::IN_BITS-1:0]  in_range_start,
  input  logic [irt_pkg::IN_BITS-1:0]  in_range_end,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  irt_pkg::status_t             out_status,
  input  logic [irt_pkg::REQ_BITS-1:0] out_request_number,
  output int                           fail_count,
  output int                           result_count
);

  typedef struct packed {
    irt_pkg::status_t             status;
    logic [irt_pkg::REQ_BITS-1:0] request_number;
  } booking_result_t;

  // local copy of the booked ranges
  logic [irt_pkg::IN_BITS-1:0]  booked_start [TABLE_CAPACITY];
  logic [irt_pkg::IN_BITS-1:0]  booked_end   [TABLE_CAPACITY];
  int                           booked_count;
  logic [irt_pkg::REQ_BITS-1:0] last_request_number;
  booking_result_t              awaited_bookings [$];

  // books one request and returns the result it should give
  function automatic booking_result_t book_range(input logic [irt_pkg::IN_BITS-1:0] lo,
                                                 input logic [irt_pkg::IN_BITS-1:0] hi);
    booking_result_t res;
    logic            clash;
    clash = 1'b0;
    // running number skips zero on wrap
    last_request_number = last_request_number + 1'b1;
    if (last_request_number == '0) last_request_number = irt_pkg::REQ_BITS'(1);
    res.request_number = last_request_number;
    if (lo > hi) begin
      res.status = irt_pkg::ST_INVALID;
    end else if (booked_count >= TABLE_CAPACITY) begin
      res.status = irt_pkg::ST_FULL;
    end else begin
      // closed ranges, so touching endpoints clash
      for (int k = 0; k < booked_count; k++) begin
        if (lo <= booked_end[k] && booked_start[k] <= hi) clash = 1'b1;
      end
      if (clash) begin
        res.status = irt_pkg::ST_OVERLAP;
      end else begin
        booked_start[booked_count] = lo;
        booked_end[booked_count]   = hi;
        booked_count++;
        res.status = irt_pkg::ST_ACCEPTED;
      end
    end
    return res;
  endfunction

  // predict on request transfers, compare on result transfers
  always @(posedge clk) begin
    booking_result_t want;
    if (!rst_n) begin
      booked_count        = 0;
      last_request_number = '0;
      fail_count          = 0;
      result_count        = 0;
      awaited_bookings.delete();
    end else begin
      if (in_valid && in_ready) begin
        awaited_bookings.insert(awaited_bookings.size(),
                                book_range(in_range_start, in_range_end));
      end
      if (out_valid && out_ready) begin
        result_count++;
        if (awaited_bookings.size() == 0) begin
          $error("result transfer with no request outstanding: status %0d number %0d",
                 out_status, out_request_number);
          fail_count++;
        end else begin
          want = awaited_bookings.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
          if (out_request_number !== want.request_number) begin
            $error("request_number mismatch: expected %0d, actual %0d",
                   want.request_number, out_request_number);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* dv/interval_reservation_table_tb.sv */
// ----------------------------------------------------------------------------
// interval_reservation_table_tb
// Drives booking requests into the reservation table and gives the verdict.
// ----------------------------------------------------------------------------
// A directed run covers the range extremes, single points, touching ends,
// start after end and nested ranges. Random requests follow: fresh ranges
// that fill the table, ranges built to clash with earlier ones, wild ranges
// and start-after-end requests, under three idling patterns and one long
// result stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module interval_reservation_table_tb;

  localparam int RANDOM_ITEMS  = 930;
  localparam int HOLD_ITEM     = 700;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 100;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam longint TIME_MAX  = 64'hFFFF_FFFF;

  logic clk;
  logic rst_n;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_wanted;
  bit  hold_started;
  int  hold_left;
  int  cycle_count;
  int  sent_count;
  int  fail_count;
  int  result_count;

  // valid ranges offered so far, used to build clashing requests
  logic [irt_pkg::IN_BITS-1:0] offered_lo [$];
  logic [irt_pkg::IN_BITS-1:0] offered_hi [$];

  irt_in_if  in_ch ();
  irt_out_if out_ch ();

  interval_reservation_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  irt_booking_checker booking_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_range_start     (in_ch.range_start),
    .in_range_end       (in_ch.range_end),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_request_number (out_ch.request_number),
    .fail_count         (fail_count),
    .result_count       (result_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_wanted && !hold_started) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_started <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("interval_reservation_table verification failed");
      $finish;
    end
  end

  function automatic logic [irt_pkg::IN_BITS-1:0] clamp_time(input longint v);
    if (v < 0) return '0;
    if (v > TIME_MAX) return '1;
    return v[irt_pkg::IN_BITS-1:0];
  endfunction

  // offers one request and returns once it has been transferred
  task automatic send_range(input logic [irt_pkg::IN_BITS-1:0] lo,
                            input logic [irt_pkg::IN_BITS-1:0] hi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.range_start <= lo;
    in_ch.range_end   <= hi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
    if (lo <= hi) begin
      offered_lo.insert(offered_lo.size(), lo);
      offered_hi.insert(offered_hi.size(), hi);
    end
  endtask

  // random request: start after end, wild, fresh band or clash with an earlier one
  task automatic make_random_range(output logic [irt_pkg::IN_BITS-1:0] lo,
                                   output logic [irt_pkg::IN_BITS-1:0] hi);
    int          kind;
    int          idx;
    longint      a;
    longint      b;
    longint      s;
    longint      e;
    kind = $urandom_range(0, 99);
    if (kind < 12 || offered_lo.size() == 0) begin
      a = longint'($urandom);
      b = longint'($urandom);
      if (kind >= 12 && offered_lo.size() == 0 && a > b) begin
        s = a; a = b; b = s;
      end
      if (kind < 12) begin
        if (a < b) begin
          s = a; a = b; b = s;
        end
        if (a == b) begin
          if (a == 0) a = 1;
          else b = a - 1;
        end
      end
      lo = clamp_time(a);
      hi = clamp_time(b);
    end else if (kind < 20) begin
      // anywhere in the time space, short
      a  = longint'($urandom);
      lo = clamp_time(a);
      hi = clamp_time(a + $urandom_range(0, 255));
    end else if (kind < 35) begin
      // small range inside one of 256 bands
      a  = (longint'($urandom_range(0, 255)) << 24) + $urandom_range(0, 1 << 23);
      lo = clamp_time(a);
      hi = clamp_time(a + $urandom_range(0, 1 << 12));
    end else begin
      idx = $urandom_range(0, offered_lo.size() - 1);
      s   = longint'(offered_lo[idx]);
      e   = longint'(offered_hi[idx]);
      case ($urandom_range(0, 4))
        0: begin
          lo = clamp_time(s);
          hi = clamp_time(e);
        end
        1: begin
          // ends on the earlier start
          lo = clamp_time(s - $urandom_range(0, 1000));
          hi = clamp_time(s);
        end
        2: begin
          // starts on the earlier end
          lo = clamp_time(e);
          hi = clamp_time(e + $urandom_range(0, 1000));
        end
        3: begin
          // nested inside
          a  = s + longint'($urandom) % (e - s + 1);
          b  = a + longint'($urandom) % (e - a + 1);
          lo = clamp_time(a);
          hi = clamp_time(b);
        end
        default: begin
          // covers the earlier range
          lo = clamp_time(s - $urandom_range(0, 1 << 16));
          hi = clamp_time(e + $urandom_range(0, 1 << 16));
        end
      endcase
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [irt_pkg::IN_BITS-1:0] lo;
    logic [irt_pkg::IN_BITS-1:0] hi;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.range_start = '0;
    in_ch.range_end   = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 30;
    recv_idle_pct     = 52;
    hold_wanted       = 1'b0;
    hold_started      = 1'b0;
    hold_left         = 0;
    cycle_count       = 0;
    sent_count        = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, single points, touching ends, nesting
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'h0000_0005, 32'h0000_0003);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'h0000_0001, 32'h0000_000A);
    send_range(32'h0000_000A, 32'h0000_0014);
    send_range(32'h0000_000B, 32'h0000_0014);
    send_range(32'h0000_0000, 32'hFFFF_FFFF);
    send_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_range(32'h0000_000F, 32'h0000_000F);
    send_range(32'h0000_0015, 32'h0000_0015);
    send_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_range(32'h8000_0000, 32'h8000_0000);
    send_range(32'h7FFF_FFFF, 32'h8000_0001);
    send_range(32'h5555_5555, 32'h5555_AAAA);
    send_range(32'h5555_0000, 32'h5556_0000);
    send_range(32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_range(32'hAAAA_AAAB, 32'hAAAA_AAA9);

    // random part, three idling patterns
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 30;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == HOLD_ITEM) hold_wanted = 1'b1;
      make_random_range(lo, hi);
      send_range(lo, hi);
    end
    in_ch.valid <= 1'b0;

    // drain
    while (result_count < sent_count) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("interval_reservation_table verification clean");
    end else begin
      $display("interval_reservation_table verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/irt_pkg.sv
hw/rtl/irt_if.sv
hw/rtl/irt_ram.sv
hw/rtl/interval_reservation_table.sv
dv/irt_booking_checker.sv
dv/interval_reservation_table_tb.sv
